// File: design/fwps_pkg.sv
package fwps_pkg;

  localparam int unsigned DefaultDepth = 16;
  // Cells examined per cycle while resolving a search
  localparam int unsigned ScanLanes = 8;

  localparam logic [1:0] ModePush   = 2'd0;
  localparam logic [1:0] ModePop    = 2'd1;
  localparam logic [1:0] ModeSearch = 2'd2;

  localparam logic [1:0] StatusDone     = 2'd0;
  localparam logic [1:0] StatusFull     = 2'd1;
  localparam logic [1:0] StatusEmpty    = 2'd2;
  localparam logic [1:0] StatusNotFound = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         item_code;
    logic signed [31:0] item_value;
  } in_req_t;

  typedef struct packed {
    logic [7:0]         out_code;
    logic signed [31:0] out_value;
    logic [4:0]         position;
    logic [1:0]         status;
  } out_rsp_t;

  typedef struct packed {
    logic [7:0]         code;
    logic signed [31:0] value;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

// File: design/fwps_cell.sv
module fwps_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fwps_pkg::cell_ctl_t ctl_i,
  input  fwps_pkg::entry_t   key_i,
  input  logic               prev_valid_i,
  input  logic               next_valid_i,
  input  fwps_pkg::entry_t   next_entry_i,
  output logic               valid_o,
  output fwps_pkg::entry_t   entry_o,
  output logic               match_o
);
  import fwps_pkg::*;

  logic   valid_q, valid_d;
  entry_t entry_q, entry_d;
  logic   load_key;

  // The first empty cell, behind an occupied one or at the head, takes a pushed entry
  assign load_key = ctl_i.push & ~valid_q & prev_valid_i;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (ctl_i.pop) begin
      valid_d = next_valid_i;
      entry_d = next_entry_i;
    end else if (load_key) begin
      valid_d = 1'b1;
      entry_d = key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;
  assign match_o = valid_q & (entry_q == key_i);

endmodule

// File: design/fifo_with_position_search.sv
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid_i / in_stall_o    | in_req_i  (mode, item_code, item_value)
// out     | output    | out_valid_o / out_stall_i  | out_rsp_o (out_code, out_value,
//         |           |                            |            position, status)
//
// Push, pop and the unused mode need no scan; the result is registered at acceptance.
// A search reports the position k of the first match on a hit, counted from 1, and not-found on a miss;
// the match scan walks up to 8 cells a cycle, from the lowest cell up.
// One request is in flight at a time; a new one is taken in the cycle its result leaves.
// Reset empties the queue at once by clearing every cell's valid bit.
module fifo_with_position_search #(
  parameter int unsigned DEPTH = fwps_pkg::DefaultDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fwps_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fwps_pkg::out_rsp_t out_rsp_o
);
  import fwps_pkg::*;

  localparam int unsigned Lanes = (DEPTH < ScanLanes) ? DEPTH : ScanLanes;
  localparam int unsigned LaneW = $clog2(Lanes);
  localparam int unsigned BaseW = $clog2(DEPTH) + 1;

  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  logic             state_q, state_d;
  logic             out_valid_q, out_valid_d;
  out_rsp_t         out_rsp_q, out_rsp_d;
  logic [DEPTH-1:0] match_q, match_d;
  logic [BaseW-1:0] base_q, base_d;

  logic             accept;
  entry_t           key;
  cell_ctl_t        ctl;
  logic [DEPTH-1:0] cell_valid;
  logic [DEPTH-1:0] cell_match;
  entry_t           cell_entry [DEPTH];

  logic             hit;
  logic [LaneW-1:0] hit_idx;
  logic [BaseW-1:0] hit_pos;

  assign in_stall_o = (state_q == StScan) | (out_valid_q & out_stall_i);
  assign accept     = in_valid_i & ~in_stall_o;
  assign key        = '{code: in_req_i.item_code, value: in_req_i.item_value};

  assign ctl.push = accept & (in_req_i.mode == ModePush) & ~cell_valid[DEPTH-1];
  assign ctl.pop  = accept & (in_req_i.mode == ModePop) & cell_valid[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   prev_valid;
    logic   next_valid;
    entry_t next_entry;
    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_rest
      assign prev_valid = cell_valid[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_entry = '0;
    end else begin : g_inner
      assign next_valid = cell_valid[i+1];
      assign next_entry = cell_entry[i+1];
    end
    fwps_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .key_i        (key),
      .prev_valid_i (prev_valid),
      .next_valid_i (next_valid),
      .next_entry_i (next_entry),
      .valid_o      (cell_valid[i]),
      .entry_o      (cell_entry[i]),
      .match_o      (cell_match[i])
    );
  end

  // Lowest matching cell among the group at the bottom of the match vector
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int l = Lanes - 1; l >= 0; l--) begin
      if (match_q[l]) begin
        hit     = 1'b1;
        hit_idx = LaneW'(l);
      end
    end
  end

  assign hit_pos = base_q + BaseW'(hit_idx) + BaseW'(1);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_rsp_d   = out_rsp_q;
    match_d     = match_q;
    base_d      = base_q;
    if (state_q == StIdle) begin
      if (accept) begin
        out_rsp_d = '0;
        case (in_req_i.mode)
          ModePush: begin
            out_valid_d = 1'b1;
            if (cell_valid[DEPTH-1]) begin
              out_rsp_d.status = StatusFull;
            end
          end
          ModePop: begin
            out_valid_d = 1'b1;
            if (cell_valid[0]) begin
              out_rsp_d.out_code  = cell_entry[0].code;
              out_rsp_d.out_value = cell_entry[0].value;
            end else begin
              out_rsp_d.status = StatusEmpty;
            end
          end
          ModeSearch: begin
            state_d = StScan;
            match_d = cell_match;
            base_d  = '0;
          end
          default: begin
            out_valid_d = 1'b1;
          end
        endcase
      end
    end else begin
      if (hit) begin
        state_d            = StIdle;
        out_valid_d        = 1'b1;
        out_rsp_d          = '0;
        out_rsp_d.position = 5'(hit_pos);
      end else if (match_q == '0) begin
        state_d          = StIdle;
        out_valid_d      = 1'b1;
        out_rsp_d        = '0;
        out_rsp_d.status = StatusNotFound;
      end else begin
        // Advance to the next group of cells
        match_d = match_q >> Lanes;
        base_d  = base_q + BaseW'(Lanes);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
    match_q   <= match_d;
    base_q    <= base_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// File: design/fwps_checker.sv
module fwps_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input fwps_pkg::in_req_t  in_req_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input fwps_pkg::out_rsp_t out_rsp_o
);
  import fwps_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed or dropped");

  a_no_take_on_blocked_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> !(out_valid_o && out_stall_i))
    else $error("request taken while the result register is blocked");

  a_not_found_no_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == StatusNotFound |->
      out_rsp_o.position == '0 && out_rsp_o.out_code == '0 && out_rsp_o.out_value == '0)
    else $error("not-found result carries data");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == StatusFull || out_rsp_o.status == StatusEmpty) |->
      out_rsp_o.position == '0 && out_rsp_o.out_code == '0 && out_rsp_o.out_value == '0)
    else $error("full or empty result carries data");

  a_pos_excludes_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.position != '0 |->
      out_rsp_o.out_code == '0 && out_rsp_o.out_value == '0 &&
      out_rsp_o.status == StatusDone)
    else $error("search hit mixed with popped data");

endmodule

bind fifo_with_position_search fwps_checker u_fwps_checker (.*);
